// ===== src/pss_pkg.sv =====
// shared types, codes and helpers of the priority slot scheduler
// no dependencies; used by pss_ctrl, pss_datapath, priority_slot_scheduler_core and the bench

package pss_pkg;

   localparam int SLOTS_DEF = 16;
   localparam logic [4:0] MAX_RUN_RESET = 5'd3;

   // command codes
   localparam logic [2:0] OP_LAUNCH   = 3'd0;
   localparam logic [2:0] OP_STOP     = 3'd1;
   localparam logic [2:0] OP_KILL     = 3'd2;
   localparam logic [2:0] OP_RESUME   = 3'd3;
   localparam logic [2:0] OP_CHILD    = 3'd4;
   localparam logic [2:0] OP_SHUTDOWN = 3'd5;

   typedef enum logic [2:0] {
      SS_EMPTY = 3'd0,
      SS_RUN   = 3'd1,
      SS_READY = 3'd2,
      SS_STOP  = 3'd3,
      SS_TERM  = 3'd4
   } slot_state_type;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_STOP = 2'd1,
      ACT_CONT = 2'd2,
      ACT_TERM = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_OK            = 4'd0,
      ST_FULL          = 4'd1,
      ST_BAD_PRIO      = 4'd2,
      ST_PRIO_TAKEN    = 4'd3,
      ST_UNKNOWN_ID    = 4'd4,
      ST_ALREADY_STOP  = 4'd5,
      ST_ALREADY_TERM  = 4'd6,
      ST_ALREADY_RUN   = 4'd7,
      ST_ALREADY_READY = 4'd8
   } status_type;

   // steps the controller asks of the datapath
   typedef enum logic [3:0] {
      DP_IDLE,
      DP_CAPTURE,
      DP_LOOKUP,
      DP_EXEC,
      DP_DEMOTE,
      DP_DISPATCH,
      DP_PREEMPT,
      DP_SHUT,
      DP_CLOSE
   } dp_cmd_type;

   typedef enum logic [3:0] {
      CS_IDLE,
      CS_LOOK,
      CS_EXEC,
      CS_DEMOTE,
      CS_RESCHK,
      CS_PREEMPT,
      CS_DISPATCH,
      CS_SHUT,
      CS_CLOSE
   } ctrl_state_type;

   typedef struct packed {
      logic out_free;     // output register can take a result this cycle
      logic op_shut;      // captured command is shutdown
      logic op_none;      // captured command is an unused code
      logic go_demote;    // exec step is followed by the demote check
      logic go_reschk;    // exec step is followed by the resume check
      logic go_dispatch;  // exec step is followed by a dispatch
      logic run_below;    // fewer tasks running than allowed
      logic preempt_ok;   // best ready beats worst running
      logic shut_last;    // shutdown walk is at the last slot
   } dp_stat_type;

   function automatic status_type state_status(input slot_state_type s);
      status_type r;
      unique case (s)
         SS_STOP: r = ST_ALREADY_STOP;
         SS_TERM: r = ST_ALREADY_TERM;
         SS_RUN:  r = ST_ALREADY_RUN;
         default: r = ST_ALREADY_READY;
      endcase
      return r;
   endfunction

endpackage

// ===== src/pss_ctrl.sv =====
// sequencer of the priority slot scheduler: walks one command through its steps
// depends on pss_pkg; drives pss_datapath through dp_cmd_type / dp_stat_type

module pss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  pss_pkg::dp_stat_type stat,
   output pss_pkg::dp_cmd_type  cmd
);

   pss_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pss_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = pss_pkg::DP_IDLE;
      req_tready = 1'b0;
      unique case (state_ff)
         pss_pkg::CS_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd      = pss_pkg::DP_CAPTURE;
               state_in = pss_pkg::CS_LOOK;
            end
         end
         pss_pkg::CS_LOOK: begin
            cmd = pss_pkg::DP_LOOKUP;
            priority if (stat.op_shut) state_in = pss_pkg::CS_SHUT;
            else if (stat.op_none)     state_in = pss_pkg::CS_CLOSE;
            else                       state_in = pss_pkg::CS_EXEC;
         end
         pss_pkg::CS_EXEC: begin
            if (stat.out_free) begin
               cmd = pss_pkg::DP_EXEC;
               priority if (stat.go_demote) state_in = pss_pkg::CS_DEMOTE;
               else if (stat.go_reschk)     state_in = pss_pkg::CS_RESCHK;
               else if (stat.go_dispatch)   state_in = pss_pkg::CS_DISPATCH;
               else                         state_in = pss_pkg::CS_CLOSE;
            end
         end
         pss_pkg::CS_DEMOTE: begin
            if (stat.out_free) begin
               cmd      = pss_pkg::DP_DEMOTE;
               state_in = pss_pkg::CS_CLOSE;
            end
         end
         pss_pkg::CS_RESCHK: begin
            priority if (stat.run_below) state_in = pss_pkg::CS_DISPATCH;
            else if (stat.preempt_ok)    state_in = pss_pkg::CS_PREEMPT;
            else                         state_in = pss_pkg::CS_CLOSE;
         end
         pss_pkg::CS_PREEMPT: begin
            if (stat.out_free) begin
               cmd      = pss_pkg::DP_PREEMPT;
               state_in = pss_pkg::CS_DISPATCH;
            end
         end
         pss_pkg::CS_DISPATCH: begin
            if (stat.out_free) begin
               cmd      = pss_pkg::DP_DISPATCH;
               state_in = pss_pkg::CS_CLOSE;
            end
         end
         pss_pkg::CS_SHUT: begin
            if (stat.out_free) begin
               cmd = pss_pkg::DP_SHUT;
               if (stat.shut_last) state_in = pss_pkg::CS_CLOSE;
            end
         end
         pss_pkg::CS_CLOSE: begin
            if (stat.out_free) begin
               cmd      = pss_pkg::DP_CLOSE;
               state_in = pss_pkg::CS_IDLE;
            end
         end
         default: state_in = pss_pkg::CS_IDLE;
      endcase
   end

endmodule

// ===== src/pss_datapath.sv =====
// datapath of the priority slot scheduler: slot table, counters, encoders, result register
// depends on pss_pkg; stepped by pss_ctrl

module pss_datapath #(
   parameter int SLOTS = pss_pkg::SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [2:0]           req_op,
   input  logic [7:0]           req_priority,
   input  logic [21:0]          req_task_id,
   input  logic                 csr_we,
   input  logic [4:0]           csr_wdata,
   input  pss_pkg::dp_cmd_type  cmd,
   output pss_pkg::dp_stat_type stat,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_action,
   output logic [21:0]          rsp_target_id,
   output logic [3:0]           rsp_target_slot,
   output logic [3:0]           rsp_status,
   output logic                 rsp_last
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;

   function automatic logic [3:0] low4(input logic [SLOT_W-1:0] s);
      logic [SLOT_W+3:0] e;
      e = {4'b0000, s};
      return e[3:0];
   endfunction

   // slot table
   pss_pkg::slot_state_type slot_st_ff [SLOTS];
   logic [21:0]             slot_id_ff [SLOTS];
   logic [CNT_W-1:0]        run_cnt_ff;
   logic [CNT_W-1:0]        occ_cnt_ff;
   logic [4:0]              max_ff;

   // captured command and lookup results
   logic [2:0]          op_ff;
   logic [7:0]          pr_ff;
   logic [21:0]         id_ff;
   logic                found_ff;
   logic [SLOT_W-1:0]   p_ff;
   logic [SLOT_W-1:0]   sh_idx_ff;
   pss_pkg::status_type st_ff;
   logic [21:0]         cid_ff;
   logic [3:0]          cslot_ff;

   // result register
   logic                rsp_valid_ff;
   logic [1:0]          act_ff;
   logic [21:0]         tid_ff;
   logic [3:0]          tslot_ff;
   logic [3:0]          status_ff;
   logic                last_ff;

   // encoders over the table
   logic              found_c, rdy_any, run_any;
   logic [SLOT_W-1:0] p_c, br_idx, wr_idx;

   always_comb begin
      found_c = 1'b0;
      p_c     = '0;
      rdy_any = 1'b0;
      br_idx  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (slot_st_ff[i] != pss_pkg::SS_EMPTY && slot_id_ff[i] == id_ff) begin
            found_c = 1'b1;
            p_c     = SLOT_W'(i);
         end
         if (slot_st_ff[i] == pss_pkg::SS_READY) begin
            rdy_any = 1'b1;
            br_idx  = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      run_any = 1'b0;
      wr_idx  = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_st_ff[i] == pss_pkg::SS_RUN) begin
            run_any = 1'b1;
            wr_idx  = SLOT_W'(i);
         end
      end
   end

   logic out_free, pr_ok, full, pr_free, demote_need, run_below;
   logic [SLOT_W-1:0]       pr_idx;
   pss_pkg::slot_state_type cur_st;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign pr_ok       = pr_ff < 8'(SLOTS);
   assign pr_idx      = pr_ff[SLOT_W-1:0];
   assign full        = occ_cnt_ff == CNT_W'(SLOTS);
   assign pr_free     = slot_st_ff[pr_idx] == pss_pkg::SS_EMPTY;
   assign cur_st      = slot_st_ff[p_ff];
   assign demote_need = (CMP_W'(run_cnt_ff) > CMP_W'(max_ff)) && run_any;
   assign run_below   = CMP_W'(run_cnt_ff) < CMP_W'(max_ff);

   // outcome of the primary step of a command
   pss_pkg::status_type     ex_status;
   logic                    ex_upd, ex_emit, ex_inc, ex_dec, ex_launch;
   logic                    go_demote, go_reschk, go_dispatch;
   logic [SLOT_W-1:0]       ex_slot;
   pss_pkg::slot_state_type ex_new;
   pss_pkg::action_type     ex_act;

   always_comb begin
      ex_status   = pss_pkg::ST_OK;
      ex_upd      = 1'b0;
      ex_emit     = 1'b0;
      ex_inc      = 1'b0;
      ex_dec      = 1'b0;
      ex_launch   = 1'b0;
      go_demote   = 1'b0;
      go_reschk   = 1'b0;
      go_dispatch = 1'b0;
      ex_slot     = p_ff;
      ex_new      = pss_pkg::SS_EMPTY;
      ex_act      = pss_pkg::ACT_NONE;
      unique case (op_ff)
         pss_pkg::OP_LAUNCH: begin
            priority if (full) ex_status = pss_pkg::ST_FULL;
            else if (!pr_ok)   ex_status = pss_pkg::ST_BAD_PRIO;
            else if (!pr_free) ex_status = pss_pkg::ST_PRIO_TAKEN;
            else begin
               ex_launch = 1'b1;
               ex_upd    = 1'b1;
               ex_slot   = pr_idx;
               ex_new    = pss_pkg::SS_RUN;
               ex_inc    = 1'b1;
               go_demote = 1'b1;
            end
         end
         pss_pkg::OP_STOP: begin
            priority if (!found_ff) ex_status = pss_pkg::ST_UNKNOWN_ID;
            else if (cur_st == pss_pkg::SS_RUN || cur_st == pss_pkg::SS_READY) begin
               ex_upd      = 1'b1;
               ex_new      = pss_pkg::SS_STOP;
               ex_emit     = 1'b1;
               ex_act      = pss_pkg::ACT_STOP;
               ex_dec      = cur_st == pss_pkg::SS_RUN;
               go_dispatch = cur_st == pss_pkg::SS_RUN;
            end else ex_status = pss_pkg::state_status(cur_st);
         end
         pss_pkg::OP_KILL: begin
            priority if (!found_ff) ex_status = pss_pkg::ST_UNKNOWN_ID;
            else if (cur_st == pss_pkg::SS_RUN || cur_st == pss_pkg::SS_READY ||
                     cur_st == pss_pkg::SS_STOP) begin
               ex_upd      = 1'b1;
               ex_new      = pss_pkg::SS_TERM;
               ex_emit     = 1'b1;
               ex_act      = pss_pkg::ACT_TERM;
               ex_dec      = cur_st == pss_pkg::SS_RUN;
               go_dispatch = cur_st == pss_pkg::SS_RUN;
            end else ex_status = pss_pkg::state_status(cur_st);
         end
         pss_pkg::OP_RESUME: begin
            priority if (!found_ff) ex_status = pss_pkg::ST_UNKNOWN_ID;
            else if (cur_st == pss_pkg::SS_STOP) begin
               ex_upd    = 1'b1;
               ex_new    = pss_pkg::SS_READY;
               go_reschk = 1'b1;
            end else ex_status = pss_pkg::state_status(cur_st);
         end
         pss_pkg::OP_CHILD: begin
            priority if (!found_ff) ex_status = pss_pkg::ST_UNKNOWN_ID;
            else if (cur_st == pss_pkg::SS_RUN) begin
               ex_upd      = 1'b1;
               ex_new      = pss_pkg::SS_TERM;
               ex_dec      = 1'b1;
               go_dispatch = 1'b1;
            end else ex_status = pss_pkg::state_status(cur_st);
         end
         default: ;
      endcase
   end

   // per-step table update and result
   logic                    upd_en, run_inc, run_dec, emit, e_last;
   logic [SLOT_W-1:0]       upd_slot;
   pss_pkg::slot_state_type upd_st;
   logic [1:0]              e_act;
   logic [21:0]             e_id;
   logic [3:0]              e_slot, e_status;
   pss_pkg::slot_state_type sh_st;

   assign sh_st = slot_st_ff[sh_idx_ff];

   always_comb begin
      upd_en   = 1'b0;
      upd_slot = p_ff;
      upd_st   = pss_pkg::SS_EMPTY;
      run_inc  = 1'b0;
      run_dec  = 1'b0;
      emit     = 1'b0;
      e_act    = pss_pkg::ACT_NONE;
      e_id     = '0;
      e_slot   = '0;
      e_status = pss_pkg::ST_OK;
      e_last   = 1'b0;
      unique case (cmd)
         pss_pkg::DP_EXEC: begin
            upd_en   = ex_upd;
            upd_slot = ex_slot;
            upd_st   = ex_new;
            run_inc  = ex_inc;
            run_dec  = ex_dec;
            emit     = ex_emit;
            e_act    = ex_act;
            e_id     = id_ff;
            e_slot   = low4(p_ff);
         end
         pss_pkg::DP_DEMOTE, pss_pkg::DP_PREEMPT: begin
            if (cmd == pss_pkg::DP_PREEMPT || demote_need) begin
               upd_en   = 1'b1;
               upd_slot = wr_idx;
               upd_st   = pss_pkg::SS_READY;
               run_dec  = 1'b1;
               emit     = 1'b1;
               e_act    = pss_pkg::ACT_STOP;
               e_id     = slot_id_ff[wr_idx];
               e_slot   = low4(wr_idx);
            end
         end
         pss_pkg::DP_DISPATCH: begin
            if (rdy_any) begin
               upd_en   = 1'b1;
               upd_slot = br_idx;
               upd_st   = pss_pkg::SS_RUN;
               run_inc  = 1'b1;
               emit     = 1'b1;
               e_act    = pss_pkg::ACT_CONT;
               e_id     = slot_id_ff[br_idx];
               e_slot   = low4(br_idx);
            end
         end
         pss_pkg::DP_SHUT: begin
            if (sh_st != pss_pkg::SS_EMPTY && sh_st != pss_pkg::SS_TERM) begin
               upd_en   = 1'b1;
               upd_slot = sh_idx_ff;
               upd_st   = pss_pkg::SS_TERM;
               run_dec  = sh_st == pss_pkg::SS_RUN;
               emit     = 1'b1;
               e_act    = pss_pkg::ACT_TERM;
               e_id     = slot_id_ff[sh_idx_ff];
               e_slot   = low4(sh_idx_ff);
            end
         end
         pss_pkg::DP_CLOSE: begin
            emit     = 1'b1;
            e_id     = cid_ff;
            e_slot   = cslot_ff;
            e_status = st_ff;
            e_last   = 1'b1;
         end
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) slot_st_ff[i] <= pss_pkg::SS_EMPTY;
         run_cnt_ff   <= '0;
         occ_cnt_ff   <= '0;
         max_ff       <= pss_pkg::MAX_RUN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) max_ff <= csr_wdata;
         if (upd_en) slot_st_ff[upd_slot] <= upd_st;
         if (run_inc)      run_cnt_ff <= run_cnt_ff + CNT_W'(1);
         else if (run_dec) run_cnt_ff <= run_cnt_ff - CNT_W'(1);
         if (cmd == pss_pkg::DP_EXEC && ex_launch) occ_cnt_ff <= occ_cnt_ff + CNT_W'(1);
         if (emit)           rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd == pss_pkg::DP_EXEC && ex_launch) slot_id_ff[pr_idx] <= id_ff;
      if (cmd == pss_pkg::DP_CAPTURE) begin
         op_ff <= req_op;
         pr_ff <= req_priority;
         id_ff <= req_task_id;
      end
      if (cmd == pss_pkg::DP_LOOKUP) begin
         found_ff  <= found_c;
         p_ff      <= p_c;
         sh_idx_ff <= '0;
         st_ff     <= pss_pkg::ST_OK;
         cid_ff    <= (op_ff <= pss_pkg::OP_CHILD) ? id_ff : 22'd0;
         priority if (op_ff == pss_pkg::OP_LAUNCH)
            cslot_ff <= pr_ok ? pr_ff[3:0] : 4'd0;
         else if (op_ff <= pss_pkg::OP_CHILD)
            cslot_ff <= found_c ? low4(p_c) : 4'd0;
         else
            cslot_ff <= 4'd0;
      end
      if (cmd == pss_pkg::DP_EXEC) st_ff <= ex_status;
      if (cmd == pss_pkg::DP_SHUT) sh_idx_ff <= sh_idx_ff + SLOT_W'(1);
      if (emit) begin
         act_ff    <= e_act;
         tid_ff    <= e_id;
         tslot_ff  <= e_slot;
         status_ff <= e_status;
         last_ff   <= e_last;
      end
   end

   always_comb begin
      stat.out_free    = out_free;
      stat.op_shut     = op_ff == pss_pkg::OP_SHUTDOWN;
      stat.op_none     = op_ff > pss_pkg::OP_SHUTDOWN;
      stat.go_demote   = go_demote;
      stat.go_reschk   = go_reschk;
      stat.go_dispatch = go_dispatch;
      stat.run_below   = run_below;
      stat.preempt_ok  = rdy_any && run_any && (br_idx < wr_idx);
      stat.shut_last   = sh_idx_ff == SLOT_W'(SLOTS - 1);
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = act_ff;
   assign rsp_target_id   = tid_ff;
   assign rsp_target_slot = tslot_ff;
   assign rsp_status      = status_ff;
   assign rsp_last        = last_ff;

endmodule

// ===== src/priority_slot_scheduler_core.sv =====
// top level of the priority slot scheduler: stream ports, controller and datapath
// depends on pss_pkg, pss_ctrl and pss_datapath
// usage
//   req channel carries one command per transfer: op in req_tuser, slot request
//   and task id in req_tdata. each command yields zero or more action results
//   (stop, continue, terminate) on the rsp channel and then one closing status
//   result flagged with rsp_tlast.
//   csr_we/csr_wdata write max_running; write it only while no command is open.
// timing
//   one command at a time, each sequencer step moving at most one result. shutdown
//   walks the table one slot per cycle while the output register is free.
//   req_tready is high while the sequencer is idle, also while the last closing
//   result still waits.
// reset
//   synchronous, active high: all slots empty, max_running back to 3, the
//   output register empty.
// backpressure
//   when rsp_tready is low the result stays in the output register and the
//   sequencer holds its current step until the register frees up.

module priority_slot_scheduler_core #(
   parameter int SLOTS = pss_pkg::SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [7:0] priority_req, [29:8] task_id, [31:30] zero
   input  logic [2:0]  req_tuser,   // [2:0] op
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [1:0] action, [23:2] target_id,
                                    // [27:24] target_slot, [31:28] status
   output logic        rsp_tlast,   // closing result of a command
   // max_running register
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata
);

   pss_pkg::dp_cmd_type  cmd;
   pss_pkg::dp_stat_type stat;

   logic [1:0]  rsp_action;
   logic [21:0] rsp_target_id;
   logic [3:0]  rsp_target_slot;
   logic [3:0]  rsp_status;

   // sequencer: one state per step of a command
   pss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // slot table, priority encoders and the output register
   pss_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_op          (req_tuser),
      .req_priority    (req_tdata[7:0]),
      .req_task_id     (req_tdata[29:8]),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_action      (rsp_action),
      .rsp_target_id   (rsp_target_id),
      .rsp_target_slot (rsp_target_slot),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_tlast)
   );

   // result fields packed from the low bit up
   assign rsp_tdata = {rsp_status, rsp_target_slot, rsp_target_id, rsp_action};

endmodule

// ===== verif/priority_slot_scheduler_core_test.sv =====
`timescale 1ns / 1ps
// self-checking bench for priority_slot_scheduler_core: directed and random commands
// against an in-bench slot table model; depends on pss_pkg and the core RTL only

module priority_slot_scheduler_core_test;

   localparam int SLOTS = pss_pkg::SLOTS_DEF;
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   typedef struct {
      pss_pkg::action_type act;
      logic [21:0]         id;
      logic [3:0]          slot;
      pss_pkg::status_type st;
      logic                last;
   } sched_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we;
   logic [4:0]  csr_wdata;

   // slot table as the bench sees it
   pss_pkg::slot_state_type task_state [SLOTS];
   logic [21:0]             task_id_of [SLOTS];
   logic [4:0]              running_limit;

   sched_result_type due_results [$];
   int  mismatch_count;
   bit  steady_flow;

   priority_slot_scheduler_core #(.SLOTS(SLOTS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic int count_in(input pss_pkg::slot_state_type s);
      int c;
      c = 0;
      for (int i = 0; i < SLOTS; i++)
         if (task_state[i] == s) c++;
      return c;
   endfunction

   function automatic int best_ready_slot();
      for (int i = 0; i < SLOTS; i++)
         if (task_state[i] == pss_pkg::SS_READY) return i;
      return -1;
   endfunction

   function automatic int worst_running_slot();
      for (int i = SLOTS - 1; i >= 0; i--)
         if (task_state[i] == pss_pkg::SS_RUN) return i;
      return -1;
   endfunction

   function automatic int slot_of_id(input logic [21:0] id);
      for (int i = 0; i < SLOTS; i++)
         if (task_state[i] != pss_pkg::SS_EMPTY && task_id_of[i] == id) return i;
      return -1;
   endfunction

   function automatic pss_pkg::status_type refusal_code(input pss_pkg::slot_state_type s);
      unique case (s)
         pss_pkg::SS_STOP: return pss_pkg::ST_ALREADY_STOP;
         pss_pkg::SS_TERM: return pss_pkg::ST_ALREADY_TERM;
         pss_pkg::SS_RUN:  return pss_pkg::ST_ALREADY_RUN;
         default:          return pss_pkg::ST_ALREADY_READY;
      endcase
   endfunction

   function automatic void queue_result(input pss_pkg::action_type act,
                                        input logic [21:0] id,
                                        input int slot, input pss_pkg::status_type st,
                                        input logic last);
      sched_result_type r;
      r.act  = act;
      r.id   = id;
      r.slot = slot[3:0];
      r.st   = st;
      r.last = last;
      due_results.push_back(r);
   endfunction

   function automatic void dispatch_ready();
      int r;
      r = best_ready_slot();
      if (r >= 0) begin
         task_state[r] = pss_pkg::SS_RUN;
         queue_result(pss_pkg::ACT_CONT, task_id_of[r], r, pss_pkg::ST_OK, 1'b0);
      end
   endfunction

   function automatic void demote_slot(input int w);
      task_state[w] = pss_pkg::SS_READY;
      queue_result(pss_pkg::ACT_STOP, task_id_of[w], w, pss_pkg::ST_OK, 1'b0);
   endfunction

   // apply one command to the table and queue every result it produces
   function automatic void apply_command(input logic [2:0] op, input logic [7:0] prio,
                                         input logic [21:0] id);
      pss_pkg::status_type     st;
      logic [21:0]             close_id;
      int                      close_slot;
      int                      p, r, w;
      pss_pkg::slot_state_type s;
      st = pss_pkg::ST_OK;
      close_id = id;
      close_slot = 0;
      unique case (op)
         pss_pkg::OP_LAUNCH: begin
            if (prio < SLOTS) close_slot = int'(prio);
            if (count_in(pss_pkg::SS_EMPTY) == 0) st = pss_pkg::ST_FULL;
            else if (prio >= SLOTS) st = pss_pkg::ST_BAD_PRIO;
            else if (task_state[prio] != pss_pkg::SS_EMPTY) st = pss_pkg::ST_PRIO_TAKEN;
            else begin
               task_id_of[prio] = id;
               task_state[prio] = pss_pkg::SS_RUN;
               if (count_in(pss_pkg::SS_RUN) > int'(running_limit)) begin
                  w = worst_running_slot();
                  if (w >= 0) demote_slot(w);
               end
            end
         end
         pss_pkg::OP_STOP, pss_pkg::OP_KILL, pss_pkg::OP_RESUME, pss_pkg::OP_CHILD: begin
            p = slot_of_id(id);
            if (p < 0) st = pss_pkg::ST_UNKNOWN_ID;
            else begin
               s = task_state[p];
               close_slot = p;
               unique case (op)
                  pss_pkg::OP_STOP: begin
                     if (s == pss_pkg::SS_RUN || s == pss_pkg::SS_READY) begin
                        task_state[p] = pss_pkg::SS_STOP;
                        queue_result(pss_pkg::ACT_STOP, id, p, pss_pkg::ST_OK, 1'b0);
                        if (s == pss_pkg::SS_RUN) dispatch_ready();
                     end else st = refusal_code(s);
                  end
                  pss_pkg::OP_KILL: begin
                     if (s == pss_pkg::SS_RUN || s == pss_pkg::SS_READY ||
                         s == pss_pkg::SS_STOP) begin
                        task_state[p] = pss_pkg::SS_TERM;
                        queue_result(pss_pkg::ACT_TERM, id, p, pss_pkg::ST_OK, 1'b0);
                        if (s == pss_pkg::SS_RUN) dispatch_ready();
                     end else st = refusal_code(s);
                  end
                  pss_pkg::OP_RESUME: begin
                     if (s == pss_pkg::SS_STOP) begin
                        task_state[p] = pss_pkg::SS_READY;
                        if (count_in(pss_pkg::SS_RUN) < int'(running_limit)) dispatch_ready();
                        else begin
                           r = best_ready_slot();
                           w = worst_running_slot();
                           // preempt only when the best waiting task outranks a runner
                           if (r >= 0 && w >= 0 && r < w) begin
                              demote_slot(w);
                              task_state[r] = pss_pkg::SS_RUN;
                              queue_result(pss_pkg::ACT_CONT, task_id_of[r], r,
                                           pss_pkg::ST_OK, 1'b0);
                           end
                        end
                     end else st = refusal_code(s);
                  end
                  default: begin
                     if (s == pss_pkg::SS_RUN) begin
                        task_state[p] = pss_pkg::SS_TERM;
                        dispatch_ready();
                     end else st = refusal_code(s);
                  end
               endcase
            end
         end
         pss_pkg::OP_SHUTDOWN: begin
            close_id = '0;
            for (int i = 0; i < SLOTS; i++)
               if (task_state[i] != pss_pkg::SS_EMPTY && task_state[i] != pss_pkg::SS_TERM)
               begin
                  task_state[i] = pss_pkg::SS_TERM;
                  queue_result(pss_pkg::ACT_TERM, task_id_of[i], i, pss_pkg::ST_OK, 1'b0);
               end
         end
         default: close_id = '0;
      endcase
      queue_result(pss_pkg::ACT_NONE, close_id, close_slot, st, 1'b1);
   endfunction

   // ---------------------------------------------------------------- drivers

   always @(posedge clock)
      rsp_tready <= steady_flow || ($urandom_range(99) >= 15);

   // leaves req_tvalid high after the transfer so back-to-back commands need no toggle
   task automatic send_cmd(input logic [2:0] op, input logic [7:0] prio,
                           input logic [21:0] id);
      if (!steady_flow)
         while ($urandom_range(99) < 15) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, id, prio};
      do @(posedge clock); while (!req_tready);
      apply_command(op, prio, id);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_max_running(input logic [4:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      running_limit = value;
   endtask

   function automatic logic [21:0] random_task_id();
      return 22'($urandom_range(22'h3FFFFF, 1));
   endfunction

   function automatic logic [21:0] known_task_id();
      int occupied [$];
      for (int i = 0; i < SLOTS; i++)
         if (task_state[i] != pss_pkg::SS_EMPTY) occupied.push_back(i);
      if (occupied.size() == 0 || $urandom_range(99) < 12) return random_task_id();
      return task_id_of[occupied[$urandom_range(occupied.size() - 1)]];
   endfunction

   function automatic logic [7:0] launch_slot();
      int free [$];
      for (int i = 0; i < SLOTS; i++)
         if (task_state[i] == pss_pkg::SS_EMPTY) free.push_back(i);
      if ($urandom_range(99) < 10) return 8'($urandom_range(255, SLOTS));
      if (free.size() != 0 && $urandom_range(99) < 75)
         return 8'(free[$urandom_range(free.size() - 1)]);
      return 8'($urandom_range(SLOTS - 1));
   endfunction

   // ---------------------------------------------------------------- checker

   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, got action %0d id %0h",
                     $time, rsp_tdata[1:0], rsp_tdata[23:2]);
            $display("%0t:   slot %0d status %0d last %0b",
                     $time, rsp_tdata[27:24], rsp_tdata[31:28], rsp_tlast);
            mismatch_count++;
         end else begin
            want = due_results.pop_front();
            if (rsp_tdata[1:0] !== want.act) begin
               $display("%0t: action mismatch: expected %0d, got %0d",
                        $time, want.act, rsp_tdata[1:0]);
               mismatch_count++;
            end
            if (rsp_tdata[23:2] !== want.id) begin
               $display("%0t: target_id mismatch: expected %0h, got %0h",
                        $time, want.id, rsp_tdata[23:2]);
               mismatch_count++;
            end
            if (rsp_tdata[27:24] !== want.slot) begin
               $display("%0t: target_slot mismatch: expected %0d, got %0d",
                        $time, want.slot, rsp_tdata[27:24]);
               mismatch_count++;
            end
            if (rsp_tdata[31:28] !== want.st) begin
               $display("%0t: status mismatch: expected %0d, got %0d",
                        $time, want.st, rsp_tdata[31:28]);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last mismatch: expected %0b, got %0b",
                        $time, want.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // launches, error order, demotion of the worst runner, duplicate ids
   task automatic test_launch();
      send_cmd(pss_pkg::OP_LAUNCH, 8'd15, 22'h3FFFFF);
      send_cmd(pss_pkg::OP_LAUNCH, 8'd0, 22'h000001);
      send_cmd(pss_pkg::OP_LAUNCH, 8'd7, 22'h2AAAAA);
      send_cmd(pss_pkg::OP_LAUNCH, 8'd3, 22'h155555);   // fourth runner, slot 15 gets stopped
      send_cmd(pss_pkg::OP_LAUNCH, 8'd3, 22'h0F0F0F);   // slot taken
      send_cmd(pss_pkg::OP_LAUNCH, 8'd16, 22'h0F0F0F);  // bad priority
      send_cmd(pss_pkg::OP_LAUNCH, 8'd255, 22'h0F0F0F);
      send_cmd(pss_pkg::OP_LAUNCH, 8'd10, 22'h000001);  // duplicate id, demoted at once
   endtask

   // stop, kill, resume and child exit across every task state
   task automatic test_task_commands();
      send_cmd(pss_pkg::OP_STOP, 8'hFF, 22'h000001);    // running, ready slot 10 continues
      send_cmd(pss_pkg::OP_STOP, 8'h00, 22'h000001);    // already stopped
      send_cmd(pss_pkg::OP_CHILD, 8'h00, 22'h000001);   // child exit of a stopped task
      send_cmd(pss_pkg::OP_RESUME, 8'h00, 22'h000001);  // preempts the worst runner
      send_cmd(pss_pkg::OP_RESUME, 8'h00, 22'h000001);  // already running
      send_cmd(pss_pkg::OP_CHILD, 8'h00, 22'h2AAAAA);   // running task exits, dispatch
      send_cmd(pss_pkg::OP_KILL, 8'h00, 22'h2AAAAA);    // already terminated
      send_cmd(pss_pkg::OP_CHILD, 8'h00, 22'h3FFFFF);   // child exit of a ready task
      send_cmd(pss_pkg::OP_RESUME, 8'h00, 22'h3FFFFF);  // already ready
      send_cmd(pss_pkg::OP_STOP, 8'h00, 22'h3FFFFF);    // stop of a ready task
      send_cmd(pss_pkg::OP_KILL, 8'h00, 22'h3FFFFF);    // kill of a stopped task
      send_cmd(pss_pkg::OP_KILL, 8'h00, 22'h155555);    // running, nothing ready
      send_cmd(pss_pkg::OP_STOP, 8'h00, 22'h123456);    // unknown ids
      send_cmd(pss_pkg::OP_KILL, 8'h00, 22'h123456);
      send_cmd(pss_pkg::OP_RESUME, 8'h00, 22'h123456);
      send_cmd(pss_pkg::OP_CHILD, 8'h00, 22'h123456);
      send_cmd(OP_SPARE_6, 8'h5A, 22'h1A2B3C);
      send_cmd(OP_SPARE_7, 8'hA5, 22'h2C3B1A);
   endtask

   task automatic run_random_commands(input int count);
      int          pick;
      logic [2:0]  op;
      logic [7:0]  prio;
      logic [21:0] id;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         prio = 8'($urandom_range(255));
         id   = known_task_id();
         if (pick < 15) begin
            op   = pss_pkg::OP_LAUNCH;
            prio = launch_slot();
            if ($urandom_range(99) >= 10) id = random_task_id();
         end else if (pick < 45) op = pss_pkg::OP_STOP;
         else if (pick < 80) op = pss_pkg::OP_RESUME;
         else if (pick < 85) op = pss_pkg::OP_KILL;
         else if (pick < 90) op = pss_pkg::OP_CHILD;
         else if (pick < 94) op = ($urandom_range(1) != 0) ? OP_SPARE_6 : OP_SPARE_7;
         else begin
            // noise: any code from launch to child exit, with arbitrary fields
            op = 3'($urandom_range(4));
            id = random_task_id();
         end
         send_cmd(op, prio, id);
      end
   endtask

   // random traffic under several run limits, extremes and out-of-range ones included
   task automatic test_random_traffic();
      logic [4:0] limits [8];
      limits = '{5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd5, 5'd3, 5'd0};
      limits[7] = 5'($urandom_range(16, 1));
      foreach (limits[i]) begin
         write_max_running(limits[i]);
         steady_flow = (i == 2);
         run_random_commands(20);
      end
      steady_flow = 1'b0;
   endtask

   task automatic test_table_full();
      for (int i = 0; i < SLOTS; i++)
         if (task_state[i] == pss_pkg::SS_EMPTY)
            send_cmd(pss_pkg::OP_LAUNCH, 8'(i), random_task_id());
      send_cmd(pss_pkg::OP_LAUNCH, 8'd255, 22'h0ABCDE);
      send_cmd(pss_pkg::OP_LAUNCH, 8'd0, 22'h0ABCDE);
   endtask

   task automatic test_shutdown();
      send_cmd(pss_pkg::OP_SHUTDOWN, 8'hFF, 22'h3FFFFF);
      send_cmd(pss_pkg::OP_RESUME, 8'h00, known_task_id());
      send_cmd(pss_pkg::OP_CHILD, 8'h00, known_task_id());
      send_cmd(pss_pkg::OP_SHUTDOWN, 8'h00, 22'h000001);   // nothing left to terminate
      send_cmd(pss_pkg::OP_LAUNCH, 8'd4, 22'h000002);
      run_random_commands(10);
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      rsp_tready  <= 1'b0;
      csr_we      <= 1'b0;
      csr_wdata   <= '0;
      steady_flow = 1'b0;
      mismatch_count = 0;
      running_limit = pss_pkg::MAX_RUN_RESET;
      for (int i = 0; i < SLOTS; i++) begin
         task_state[i] = pss_pkg::SS_EMPTY;
         task_id_of[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_launch();
      test_task_commands();
      test_random_traffic();
      test_table_full();
      test_shutdown();

      req_tvalid <= 1'b0;
      for (int n = 0; n < 5000 && due_results.size() != 0; n++) @(posedge clock);
      repeat (SLOTS + 8) @(posedge clock);
      if (due_results.size() != 0) begin
         $display("%0t: %0d results never arrived, next expected action %0d id %0h",
                  $time, due_results.size(), due_results[0].act, due_results[0].id);
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("priority_slot_scheduler_core_test: PASS");
      else
         $display("priority_slot_scheduler_core_test: FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("priority_slot_scheduler_core_test: FAIL");
      $finish;
   end

endmodule
